// ===== rtl/mi3_pkg.sv =====
package mi3_pkg;

  // field widths and fixed-point formats
  localparam int ELEM_W   = 16;
  localparam int FRAC_W   = 8;
  localparam int OUT_W    = 32;
  localparam int OUT_FRAC = 16;
  localparam int DET_W    = 50;
  localparam int CF_W     = 2 * ELEM_W + 1;
  localparam int CM_W     = 2 * ELEM_W;
  localparam int DP_W     = ELEM_W + CF_W;

  // quotient scaling: inverse = cofactor * 2^SHIFT / det
  localparam int SHIFT    = FRAC_W + OUT_FRAC;
  localparam int QBITS    = OUT_W;
  localparam int LOWB     = QBITS - SHIFT;

  // pipeline depth
  localparam int CF_ST    = 5;
  localparam int DIV_ST   = QBITS + 1;
  localparam int PIPE_ST  = 1 + CF_ST + DIV_ST;

  // packed port widths
  localparam int IN_DW    = 9 * ELEM_W;
  localparam int OUT_DW   = ((9 * OUT_W + DET_W + 7) / 8) * 8;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [CF_W-1:0]   cof_t;
  typedef logic        [CM_W-1:0]   cmag_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic        [DET_W-1:0]  dmag_t;
  typedef logic        [QBITS-1:0]  quo_t;

  // what one divider lane hands to the merge stage
  typedef struct packed {
    quo_t  q;
    dmag_t r;
    dmag_t den;
    logic  ovf;
    logic  neg;
  } lane_res_t;

endpackage

// ===== rtl/mi3_cofactor.sv =====
module mi3_cofactor import mi3_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  elem_t a [9],
  output cmag_t cmag [9],
  output logic  cneg [9],
  output det_t  det,
  output dmag_t dmag,
  output logic  dneg
);

  // operand pairs of the 18 cofactor products, cofactor k = pa[k] - pb[k]
  elem_t pa_x [9], pa_y [9], pb_x [9], pb_y [9];

  always_comb begin
    pa_x[0] = a[4]; pa_y[0] = a[8]; pb_x[0] = a[5]; pb_y[0] = a[7];
    pa_x[1] = a[5]; pa_y[1] = a[6]; pb_x[1] = a[3]; pb_y[1] = a[8];
    pa_x[2] = a[3]; pa_y[2] = a[7]; pb_x[2] = a[4]; pb_y[2] = a[6];
    pa_x[3] = a[2]; pa_y[3] = a[7]; pb_x[3] = a[1]; pb_y[3] = a[8];
    pa_x[4] = a[0]; pa_y[4] = a[8]; pb_x[4] = a[2]; pb_y[4] = a[6];
    pa_x[5] = a[1]; pa_y[5] = a[6]; pb_x[5] = a[0]; pb_y[5] = a[7];
    pa_x[6] = a[1]; pa_y[6] = a[5]; pb_x[6] = a[2]; pb_y[6] = a[4];
    pa_x[7] = a[2]; pa_y[7] = a[3]; pb_x[7] = a[0]; pb_y[7] = a[5];
    pa_x[8] = a[0]; pa_y[8] = a[4]; pb_x[8] = a[1]; pb_y[8] = a[3];
  end

  logic signed [CM_W-1:0] pa [9], pb [9];
  cof_t  cf [9], cf2 [9];
  elem_t r0a [3], r0b [3];
  logic signed [DP_W-1:0] dp [3];
  det_t  det4;
  cmag_t cm4 [9];
  logic  cn4 [9];

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        pa[k] <= pa_x[k] * pa_y[k];
        pb[k] <= pb_x[k] * pb_y[k];
      end
      for (int j = 0; j < 3; j++) r0a[j] <= a[j];
    end
  end

  // stage 2: cofactors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) cf[k] <= CF_W'(pa[k]) - CF_W'(pb[k]);
      for (int j = 0; j < 3; j++) r0b[j] <= r0a[j];
    end
  end

  // stage 3: first-row expansion products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) dp[j] <= DP_W'(r0b[j]) * DP_W'(cf[j]);
      for (int k = 0; k < 9; k++) cf2[k] <= cf[k];
    end
  end

  // stage 4: determinant sum and cofactor magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      det4 <= DET_W'(dp[0]) + DET_W'(dp[1]) + DET_W'(dp[2]);
      for (int k = 0; k < 9; k++) begin
        cn4[k] <= cf2[k][CF_W-1];
        cm4[k] <= cf2[k][CF_W-1] ? CM_W'(-cf2[k]) : CM_W'(cf2[k]);
      end
    end
  end

  // stage 5: determinant magnitude, cofactor magnitudes kept in step
  always_ff @(posedge clk) begin
    if (en) begin
      det  <= det4;
      dneg <= det4[DET_W-1];
      dmag <= det4[DET_W-1] ? dmag_t'(-det4) : dmag_t'(det4);
      for (int k = 0; k < 9; k++) begin
        cneg[k] <= cn4[k];
        cmag[k] <= cm4[k];
      end
    end
  end

endmodule

// ===== rtl/mi3_div_lane.sv =====
module mi3_div_lane import mi3_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  cmag_t     num,
  input  dmag_t     den,
  input  logic      neg,
  output lane_res_t res
);

  dmag_t            r    [QBITS+1];
  quo_t             q    [QBITS+1];
  dmag_t            dd   [QBITS+1];
  logic [LOWB-1:0]  low  [QBITS+1];
  logic             ovf  [QBITS+1];
  logic             sgn  [QBITS+1];

  // setup: quotient overflow check and leading partial remainder
  always_ff @(posedge clk) begin
    if (en) begin
      ovf[0] <= (DET_W + LOWB)'(num) >= {den, LOWB'(0)};
      r[0]   <= dmag_t'(num >> LOWB);
      low[0] <= num[LOWB-1:0];
      q[0]   <= '0;
      dd[0]  <= den;
      sgn[0] <= neg;
    end
  end

  // one restoring step per stage, quotient msb first
  for (genvar j = 0; j < QBITS; j++) begin : g_step
    localparam int K = QBITS - 1 - j;
    logic           bin;
    logic [DET_W:0] t;
    logic           ge;

    if (K >= SHIFT) begin : g_num
      assign bin = low[j][K - SHIFT];
    end else begin : g_zero
      assign bin = 1'b0;
    end

    assign t  = {r[j], bin};
    assign ge = t >= {1'b0, dd[j]};

    always_ff @(posedge clk) begin
      if (en) begin
        r[j+1]   <= ge ? DET_W'(t - {1'b0, dd[j]}) : DET_W'(t);
        q[j+1]   <= {q[j][QBITS-2:0], ge};
        dd[j+1]  <= dd[j];
        low[j+1] <= low[j];
        ovf[j+1] <= ovf[j];
        sgn[j+1] <= sgn[j];
      end
    end
  end

  assign res.q   = q[QBITS];
  assign res.r   = r[QBITS];
  assign res.den = dd[QBITS];
  assign res.ovf = ovf[QBITS];
  assign res.neg = sgn[QBITS];

endmodule

// ===== rtl/matrix3x3_inverse.sv =====
// 3x3 matrix inverse by the adjugate. One matrix of signed Q8.8 elements per
// input transaction; each gives one output transaction with the nine inverse
// elements in signed Q16.16 (rounded to nearest, ties away from zero,
// saturated), the exact determinant in signed Q26.24 and an invertible flag.
// A singular matrix gives an all-zero inverse and invertible = 0. The block
// takes one matrix per clock while the output is not stalled; the path runs
// through the input register, five cofactor stages, the 33-stage restoring
// divider (setup plus 32 steps) in each of the nine lanes, and the output register.
// A two-entry output buffer lets input keep flowing while the output stalls
// until its skid entry fills; the pipeline then halts.
module matrix3x3_inverse import mi3_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_DW-1:0]  s_tdata,  // a00 a01 a02 a10 a11 a12 a20 a21 a22
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_DW-1:0] m_tdata,  // inv00 .. inv22, determinant, zero pad
  output logic [0:0]        m_tuser   // invertible
);

  localparam int DDLY = DIV_ST;

  logic        en;
  logic [PIPE_ST-1:0] v;
  elem_t       a [9];
  cmag_t       cmag [9];
  logic        cneg [9];
  det_t        det5;
  dmag_t       dmag;
  logic        dneg;
  lane_res_t   lres [9];
  det_t        dpipe [DDLY];
  logic [OUT_W-1:0] inv [9];
  logic [OUT_DW-1:0] res_data;
  logic        res_inv;
  logic        sk_v;
  logic [OUT_DW-1:0] sk_data;
  logic        sk_inv;

  // pipeline advances while the skid entry is free
  assign en       = !sk_v;
  assign s_tready = en;

  // valid tracking through the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[PIPE_ST-2:0], s_tvalid};
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) a[k] <= s_tdata[k*ELEM_W +: ELEM_W];
    end
  end

  mi3_cofactor u_cof (
    .clk  (clk),
    .en   (en),
    .a    (a),
    .cmag (cmag),
    .cneg (cneg),
    .det  (det5),
    .dmag (dmag),
    .dneg (dneg)
  );

  // lane (i,j) divides transposed cofactor (j,i) by the determinant
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      mi3_div_lane u_lane (
        .clk (clk),
        .en  (en),
        .num (cmag[j*3+i]),
        .den (dmag),
        .neg (cneg[j*3+i] ^ dneg),
        .res (lres[i*3+j])
      );
    end
  end

  // determinant delay to line up with the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      dpipe[0] <= det5;
      for (int k = 1; k < DDLY; k++) dpipe[k] <= dpipe[k-1];
    end
  end

  // merge: round, saturate, apply sign, zero a singular result
  always_comb begin
    logic            rnd;
    logic [QBITS:0]  qq;
    logic            nz;
    nz = dpipe[DDLY-1] != '0;
    for (int k = 0; k < 9; k++) begin
      rnd = {lres[k].r, 1'b0} >= {1'b0, lres[k].den};
      qq  = {1'b0, lres[k].q} + (QBITS+1)'(rnd);
      if (!nz) begin
        inv[k] = '0;
      end else if (!lres[k].neg) begin
        inv[k] = (lres[k].ovf || qq > (QBITS+1)'({1'b0, {(OUT_W-1){1'b1}}}))
               ? {1'b0, {(OUT_W-1){1'b1}}} : qq[OUT_W-1:0];
      end else begin
        inv[k] = (lres[k].ovf || qq > (QBITS+1)'({1'b1, {(OUT_W-1){1'b0}}}))
               ? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(-qq);
      end
    end
    res_data = '0;
    for (int k = 0; k < 9; k++) res_data[k*OUT_W +: OUT_W] = inv[k];
    res_data[9*OUT_W +: DET_W] = dpipe[DDLY-1];
    res_inv = nz;
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sk_v     <= 1'b0;
    end else if (sk_v) begin
      if (m_tready) begin
        m_tvalid <= 1'b1;
        sk_v     <= 1'b0;
      end
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= v[PIPE_ST-1];
    end else if (v[PIPE_ST-1]) begin
      sk_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v) begin
      if (m_tready) begin
        m_tdata <= sk_data;
        m_tuser <= sk_inv;
      end
    end else if (!m_tvalid || m_tready) begin
      m_tdata <= res_data;
      m_tuser <= res_inv;
    end else begin
      sk_data <= res_data;
      sk_inv  <= res_inv;
    end
  end

endmodule

// ===== rtl/mi3_checker.sv =====
module mi3_checker import mi3_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic [IN_DW-1:0]  s_tdata,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_DW-1:0] m_tdata,
  input logic [0:0]        m_tuser
);

  // singular result carries a zero inverse and a zero determinant
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("singular result not zero");

  // invertible flag agrees with the determinant
  a_flag_det: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[9*OUT_W +: DET_W] != '0))
    else $error("invertible with zero determinant");

  // no output transaction right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled output changed");

  // a stalled input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata)))
    else $error("stalled input changed");

endmodule

bind matrix3x3_inverse mi3_checker u_mi3_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
